// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== design/pngunf_pkg.sv =====
package pngunf_pkg;

  // Default maximum image width in pixels
  localparam int MAX_WIDTH_DEF = 1024;

  // Queue depth between front and back
  localparam int QDEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

  // Field widths
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;
  localparam int BYTE_W       = 8;

  // Per-row filter types
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filter_t;

  // Classification of one queued word
  typedef struct packed {
    filter_t filter;
    logic    row0;
    logic    err;
    logic    end_row;
    logic    end_img;
  } ctrl_t;

  // Paeth predictor on unsigned bytes
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    // pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = da + db;
    pa = da[10] ? 10'(-da) : 10'(da);
    pb = db[10] ? 10'(-db) : 10'(db);
    pc = dc[10] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// ===== design/pngunf_front.sv =====
// Stream parser: config registers, row/column tracking, filter byte capture.
module pngunf_front import pngunf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH * 4)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  q_full,
  output logic                  push,
  output ctrl_t                 ent_ctrl,
  output logic [BYTE_W-1:0]     ent_byte,
  output logic [CW-1:0]         ent_col
);

  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int RBW = EW + 2;

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;
  logic [CW-1:0]           col_r, col_nxt;
  logic [CFG_HEIGHT_W-1:0] row_r, row_nxt;
  filter_t                 filt_r, filt_nxt;
  logic                    await_r, await_nxt;
  logic                    halted_r, halted_nxt;

  logic [EW-1:0]           wid_eff;
  logic [RBW-1:0]          row_bytes;
  logic [RBW-1:0]          col_inc;
  logic [CFG_HEIGHT_W-1:0] h_eff;
  logic [CFG_HEIGHT_W:0]   row_inc;
  logic                    end_row;
  logic                    end_img;
  logic                    accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Clamp configured geometry
  always_comb begin
    if (width_r == '0) begin
      wid_eff = EW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      wid_eff = EW'(MAX_WIDTH);
    end else begin
      wid_eff = EW'(width_r);
    end
  end
  assign h_eff     = (height_r == '0) ? CFG_HEIGHT_W'(1) : height_r;
  assign row_bytes = {wid_eff, 2'b00};
  assign col_inc   = RBW'(col_r) + RBW'(1);
  assign row_inc   = {1'b0, row_r} + (CFG_HEIGHT_W + 1)'(1);
  assign end_row   = col_inc >= row_bytes;
  assign end_img   = end_row && (row_inc >= {1'b0, h_eff});

  // Classify the accepted byte
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    filt_nxt   = filt_r;
    await_nxt  = await_r;
    halted_nxt = halted_r;
    push       = 1'b0;
    ent_ctrl   = '{filter: filt_r, row0: (row_r == '0), err: 1'b0,
                   end_row: end_row, end_img: end_img};
    ent_byte   = in_byte;
    ent_col    = col_r;
    if (accept && !halted_r) begin
      if (await_r) begin
        if (in_byte > BYTE_W'(FLT_PAETH)) begin
          push       = 1'b1;
          halted_nxt = 1'b1;
          ent_ctrl   = '{filter: FLT_NONE, row0: 1'b1, err: 1'b1,
                         end_row: 1'b0, end_img: 1'b0};
        end else begin
          filt_nxt  = filter_t'(in_byte[2:0]);
          await_nxt = 1'b0;
        end
      end else begin
        push = 1'b1;
        if (end_row) begin
          col_nxt   = '0;
          await_nxt = 1'b1;
          row_nxt   = end_img ? '0 : row_inc[CFG_HEIGHT_W-1:0];
        end else begin
          col_nxt = col_inc[CW-1:0];
        end
      end
    end
  end

  // State and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_WIDTH_W'(1);
      height_r <= CFG_HEIGHT_W'(1);
      col_r    <= '0;
      row_r    <= '0;
      filt_r   <= FLT_NONE;
      await_r  <= 1'b1;
      halted_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      filt_r   <= filt_nxt;
      await_r  <= await_nxt;
      halted_r <= halted_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_WIDTH:  width_r  <= cfg_data[CFG_WIDTH_W-1:0];
          CFG_IDX_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_no_push_halted, halted_r && push, "word queued after halt")
  `ASSERT_NEVER(a_halt_at_filter, halted_r && !await_r, "halted outside filter position")

endmodule

// ===== design/pngunf_queue.sv =====
// Small FIFO decoupling the parser from the reconstruction pipeline.
module pngunf_queue import pngunf_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] rdata
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  logic [DW-1:0] mem_r [QDEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == NW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rptr_r];

  // Pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_q_overflow, push && full, "push into full queue")
  `ASSERT_NEVER(a_q_underflow, pop && !not_empty, "pop from empty queue")

endmodule

// ===== design/pngunf_back.sv =====
// Reconstruction pipeline: line buffer read, predictor, output register.
module pngunf_back import pngunf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH * 4)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ctrl_t             q_ctrl,
  input  logic [BYTE_W-1:0] q_byte,
  input  logic [CW-1:0]     q_col,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic [1:0]        out_channel,
  output logic              out_status,
  output logic              out_last_of_row,
  output logic              out_last_of_image
);

  localparam int MEM_D = MAX_WIDTH * 4;

  logic [BYTE_W-1:0] line_mem [MEM_D];
  logic [BYTE_W-1:0] rd_data_r;

  logic              s1_valid_r;
  ctrl_t             s1_ctrl_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [CW-1:0]     s1_col_r;

  logic [BYTE_W-1:0] left_r [4];
  logic [BYTE_W-1:0] ul_r [4];

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [1:0]        out_ch_r;
  logic              out_status_r;
  logic              out_eor_r;
  logic              out_eoi_r;

  logic              adv;
  logic              wr_en;
  logic [1:0]        ch;
  logic              has_left;
  logic [BYTE_W-1:0] a, b, c, pred, val;
  logic [BYTE_W:0]   ab_sum;

  // Pipeline moves when the output register is free or being drained
  assign adv   = !out_valid_r || !out_stall;
  assign pop   = adv && q_valid;
  assign wr_en = adv && s1_valid_r && !s1_ctrl_r.err;

  // Neighbors of the current sample
  assign ch       = s1_col_r[1:0];
  assign has_left = 32'(s1_col_r) >= 32'd4;
  assign a        = has_left ? left_r[ch] : '0;
  assign b        = s1_ctrl_r.row0 ? '0 : rd_data_r;
  assign c        = (has_left && !s1_ctrl_r.row0) ? ul_r[ch] : '0;
  assign ab_sum   = {1'b0, a} + {1'b0, b};

  // Predictor select
  always_comb begin
    unique case (s1_ctrl_r.filter)
      FLT_NONE:  pred = '0;
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = ab_sum[BYTE_W:1];
      FLT_PAETH: pred = paeth(a, b, c);
      default:   pred = '0;
    endcase
  end
  assign val = s1_byte_r + pred;

  // Stage 1 and output register valid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  // Stage payloads and neighbor registers
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ctrl_r <= q_ctrl;
      s1_byte_r <= q_byte;
      s1_col_r  <= q_col;
    end
    if (adv && s1_valid_r) begin
      if (s1_ctrl_r.err) begin
        out_byte_r   <= '0;
        out_ch_r     <= '0;
        out_status_r <= 1'b1;
        out_eor_r    <= 1'b0;
        out_eoi_r    <= 1'b0;
      end else begin
        out_byte_r   <= val;
        out_ch_r     <= ch;
        out_status_r <= 1'b0;
        out_eor_r    <= s1_ctrl_r.end_row;
        out_eoi_r    <= s1_ctrl_r.end_img;
      end
    end
    if (wr_en) begin
      left_r[ch] <= val;
      ul_r[ch]   <= b;
    end
  end

  // Line buffer: one read and one write per cycle, both held while the output stalls
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= line_mem[q_col];
    end
    if (wr_en) begin
      line_mem[s1_col_r] <= val;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_channel       = out_ch_r;
  assign out_status        = out_status_r;
  assign out_last_of_row   = out_eor_r;
  assign out_last_of_image = out_eoi_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_err_payload, !(out_valid_r && out_status_r) || (out_byte_r == '0 && !out_eor_r && !out_eoi_r), "error word with payload")
  `ASSERT_ALWAYS(a_eoi_has_eor, !(out_valid_r && out_eoi_r) || out_eor_r, "image end without row end")

endmodule

// ===== design/png_rgba8_scanline_unfilter.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | in_byte
// out     | output    | out_valid/out_stall | out_byte, out_channel, out_status,
//         |           |                     | out_last_of_row, out_last_of_image
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; an accepted sample passes through
// a queue slot, the line buffer read register and the output register before out_valid.
// The single-ported-per-direction line buffer does one read and one write a cycle unless out_stall holds it.
// Reset is synchronous and active low; the line buffer is not cleared.
// in_stall rises only while the two-word queue is full; out_stall freezes the back end.
module png_rgba8_scanline_unfilter import pngunf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_byte,
  output logic [1:0]            out_channel,
  output logic                  out_status,
  output logic                  out_last_of_row,
  output logic                  out_last_of_image
);

  localparam int CW = $clog2(MAX_WIDTH * 4);
  localparam int DW = $bits(ctrl_t) + BYTE_W + CW;

  logic              push, pop, q_full, q_valid;
  ctrl_t             ent_ctrl, q_ctrl;
  logic [BYTE_W-1:0] ent_byte, q_byte;
  logic [CW-1:0]     ent_col, q_col;
  logic [DW-1:0]     q_wdata, q_rdata;

  pngunf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .push      (push),
    .ent_ctrl  (ent_ctrl),
    .ent_byte  (ent_byte),
    .ent_col   (ent_col)
  );

  // Pack queue word
  assign q_wdata = {ent_ctrl, ent_byte, ent_col};
  assign {q_ctrl, q_byte, q_col} = q_rdata;

  pngunf_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  pngunf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ctrl            (q_ctrl),
    .q_byte            (q_byte),
    .q_col             (q_col),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_channel       (out_channel),
    .out_status        (out_status),
    .out_last_of_row   (out_last_of_row),
    .out_last_of_image (out_last_of_image)
  );

endmodule
